// ===== design/fadu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fadu_pkg;

    localparam logic [1:0] FUNC_TEMP = 2'd0;
    localparam logic [1:0] FUNC_FIRE = 2'd1;
    localparam logic [1:0] FUNC_DOOR = 2'd2;

    localparam logic [2:0] KIND_ALARM     = 3'd0;
    localparam logic [2:0] KIND_OPEN      = 3'd1;
    localparam logic [2:0] KIND_CONFIRM   = 3'd2;
    localparam logic [2:0] KIND_DOOR_FULL = 3'd3;
    localparam logic [2:0] KIND_DET_FULL  = 3'd4;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_MIN_DET   = 2'd1;
    localparam logic [1:0] REG_PERIOD    = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input word
        logic prune_start; // clear prune index and kept count
        logic prune_rd;    // issue detection read at prune index
        logic prune_chk;   // evaluate returned detection, compact
        logic det_store;   // append stamp, commit kept count
        logic door_start;
        logic door_rd;
        logic door_chk;
        logic door_store;
        logic scan_start;  // open list walk
        logic scan_rd;
        logic set_alarm;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic pass;        // report qualifies
        logic prune_more;  // entries remain to prune
        logic det_full;
        logic count_hit;
        logic door_more;
        logic door_match;
        logic door_full;
        logic scan_more;
        logic alarm;
    } t_sts;

endpackage
`default_nettype wire

// ===== design/fadu_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fadu_datapath #(
    parameter int DETECTION_DEPTH = 64,
    parameter int DOOR_DEPTH      = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fadu_pkg::t_cmd      i_cmd,
    output fadu_pkg::t_sts           o_sts,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [31:0]         i_cfg_data,
    input  wire logic [47:0]         i_now_us,
    input  wire logic [47:0]         i_reading_time_us,
    input  wire logic signed [15:0]  i_temperature,
    input  wire logic [31:0]         i_door_addr,
    input  wire logic [15:0]         i_door_port,
    output logic [31:0]              o_scan_addr,
    output logic [15:0]              o_scan_port,
    output logic [31:0]              o_in_addr,
    output logic [15:0]              o_in_port
);
    localparam int DW = $clog2(DETECTION_DEPTH + 1);
    localparam int DA = (DETECTION_DEPTH > 1) ? $clog2(DETECTION_DEPTH) : 1;
    localparam int RW = $clog2(DOOR_DEPTH + 1);
    localparam int RA = (DOOR_DEPTH > 1) ? $clog2(DOOR_DEPTH) : 1;

    logic signed [15:0] r_thr;
    logic [6:0]         r_min;
    logic [30:0]        r_period;

    logic [47:0]        r_now, r_stamp;
    logic signed [15:0] r_temp;
    logic [31:0]        r_addr;
    logic [15:0]        r_port;

    logic [47:0] r_det_mem [DETECTION_DEPTH];
    logic [47:0] r_door_mem [DOOR_DEPTH];
    logic [47:0] r_det_q, r_door_q;

    logic [DW-1:0] r_det_cnt, r_rd_i, r_kept;
    logic [RW-1:0] r_door_cnt, r_dr_i;
    logic          r_alarm, r_match;

    // ages as 49-bit signed differences
    logic signed [48:0] w_age_in, w_age_st;
    assign w_age_in = $signed({1'b0, r_now}) - $signed({1'b0, r_stamp});
    assign w_age_st = $signed({1'b0, r_now}) - $signed({1'b0, r_det_q});

    logic signed [48:0] w_per;
    assign w_per = $signed({18'd0, r_period});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= '0;
            r_min    <= 7'd1;
            r_period <= 31'd1000000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fadu_pkg::REG_THRESHOLD: r_thr    <= $signed(i_cfg_data[15:0]);
                fadu_pkg::REG_MIN_DET:   r_min    <= i_cfg_data[6:0];
                fadu_pkg::REG_PERIOD:    r_period <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now   <= i_now_us;
            r_stamp <= i_reading_time_us;
            r_temp  <= i_temperature;
            r_addr  <= i_door_addr;
            r_port  <= i_door_port;
        end
    end

    // detection store: one read and one write per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.prune_rd)
            r_det_q <= r_det_mem[r_rd_i[DA-1:0]];
        if (i_cmd.prune_chk && (w_age_st < w_per))
            r_det_mem[r_kept[DA-1:0]] <= r_det_q;
        else if (i_cmd.det_store && (r_kept != DW'(DETECTION_DEPTH)))
            r_det_mem[r_kept[DA-1:0]] <= r_stamp;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.door_rd || i_cmd.scan_rd)
            r_door_q <= r_door_mem[r_dr_i[RA-1:0]];
        if (i_cmd.door_store)
            r_door_mem[r_door_cnt[RA-1:0]] <= {r_addr, r_port};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_cnt  <= '0;
            r_door_cnt <= '0;
            r_alarm    <= 1'b0;
            r_rd_i     <= '0;
            r_kept     <= '0;
            r_dr_i     <= '0;
            r_match    <= 1'b0;
        end else begin
            if (i_cmd.prune_start) begin
                r_rd_i <= '0;
                r_kept <= '0;
            end
            if (i_cmd.prune_rd)
                r_rd_i <= r_rd_i + 1'b1;
            if (i_cmd.prune_chk && (w_age_st < w_per))
                r_kept <= r_kept + 1'b1;
            if (i_cmd.det_store) begin
                if (r_kept == DW'(DETECTION_DEPTH))
                    r_det_cnt <= r_kept;
                else
                    r_det_cnt <= r_kept + 1'b1;
            end
            if (i_cmd.door_start || i_cmd.scan_start) begin
                r_dr_i  <= '0;
                r_match <= 1'b0;
            end
            if (i_cmd.door_rd || i_cmd.scan_rd)
                r_dr_i <= r_dr_i + 1'b1;
            if (i_cmd.door_chk && (r_door_q[15:0] == r_port))
                r_match <= 1'b1;
            if (i_cmd.door_store)
                r_door_cnt <= r_door_cnt + 1'b1;
            if (i_cmd.set_alarm)
                r_alarm <= 1'b1;
        end
    end

    always_comb begin
        o_sts.pass       = (r_temp >= r_thr) && !(w_age_in > w_per);
        o_sts.prune_more = (r_rd_i < r_det_cnt);
        o_sts.det_full   = (r_kept == DW'(DETECTION_DEPTH));
        // count after append is r_det_cnt, compared once stored
        o_sts.count_hit  = ({1'b0, r_min} <= 8'(r_det_cnt));
        o_sts.door_more  = (r_dr_i < r_door_cnt);
        o_sts.door_match = r_match;
        o_sts.door_full  = (r_door_cnt == RW'(DOOR_DEPTH));
        o_sts.scan_more  = (r_dr_i < r_door_cnt);
        o_sts.alarm      = r_alarm;
    end

    assign o_scan_addr = r_door_q[47:16];
    assign o_scan_port = r_door_q[15:0];
    assign o_in_addr   = r_addr;
    assign o_in_port   = r_port;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.det_store |-> (r_kept <= DW'(DETECTION_DEPTH))) else $error("kept count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_det_cnt <= DW'(DETECTION_DEPTH)) else $error("detection count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_door_cnt <= RW'(DOOR_DEPTH)) else $error("door count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_alarm) |-> r_alarm) else $error("alarm cleared");

endmodule
`default_nettype wire

// ===== design/fadu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fadu_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [1:0]      i_func,
    output fadu_pkg::t_cmd       o_cmd,
    input  wire fadu_pkg::t_sts  i_sts,
    input  wire logic [31:0]     i_scan_addr,
    input  wire logic [15:0]     i_scan_port,
    input  wire logic [31:0]     i_in_addr,
    input  wire logic [15:0]     i_in_port,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [2:0]           o_kind,
    output logic [31:0]          o_out_door_addr,
    output logic [15:0]          o_out_door_port,
    output logic                 o_last
);
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_DISP  = 13'b0000000000010,
        S_PRD   = 13'b0000000000100,
        S_PCHK  = 13'b0000000001000,
        S_PEND  = 13'b0000000010000,
        S_EVAL  = 13'b0000000100000,
        S_DRD   = 13'b0000001000000,
        S_DCHK  = 13'b0000010000000,
        S_DEND  = 13'b0000100000000,
        S_SRD   = 13'b0001000000000,
        S_SCHK  = 13'b0010000000000,
        S_EMIT  = 13'b0100000000000,
        S_CONF  = 13'b1000000000000
    } t_state;

    t_state      r_state, n_state;
    logic [1:0]  r_func;
    logic        r_ov, r_olast, r_scan;
    logic [2:0]  r_okind;
    logic [31:0] r_oaddr;
    logic [15:0] r_oport;
    logic        w_push, w_free;
    logic [2:0]  w_kind;
    logic [31:0] w_addr;
    logic [15:0] w_port;
    logic        w_last;

    assign w_free  = !r_ov || i_ready;
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        w_push  = 1'b0;
        w_kind  = fadu_pkg::KIND_ALARM;
        w_addr  = '0;
        w_port  = '0;
        w_last  = 1'b0;
        case (r_state)
            S_IDLE: if (i_valid) begin
                o_cmd.load = 1'b1;
                n_state    = S_DISP;
            end
            S_DISP: begin
                if (r_func == fadu_pkg::FUNC_TEMP && !i_sts.alarm && i_sts.pass) begin
                    o_cmd.prune_start = 1'b1;
                    n_state = S_PRD;
                end else if (r_func == fadu_pkg::FUNC_FIRE && !i_sts.alarm) begin
                    o_cmd.set_alarm  = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state = S_EVAL;
                end else if (r_func == fadu_pkg::FUNC_DOOR && i_sts.alarm) begin
                    n_state = S_CONF;
                end else if (r_func == fadu_pkg::FUNC_DOOR) begin
                    o_cmd.door_start = 1'b1;
                    n_state = S_DRD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PRD: begin
                if (i_sts.prune_more) begin
                    o_cmd.prune_rd = 1'b1;
                    n_state = S_PCHK;
                end else begin
                    o_cmd.det_store = 1'b1;
                    n_state = S_PEND;
                end
            end
            S_PCHK: begin
                o_cmd.prune_chk = 1'b1;
                n_state = S_PRD;
            end
            S_PEND: begin
                if (i_sts.det_full) begin
                    if (w_free) begin
                        w_push = 1'b1;
                        w_kind = fadu_pkg::KIND_DET_FULL;
                        w_last = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (i_sts.count_hit) begin
                    o_cmd.set_alarm  = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state = S_EVAL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            // door walk index was cleared on entry, so scan_more is current
            S_EVAL: if (w_free) begin
                w_push = 1'b1;
                w_kind = fadu_pkg::KIND_ALARM;
                w_last = !i_sts.scan_more;
                n_state = S_SRD;
            end
            S_SRD: begin
                if (i_sts.scan_more) begin
                    o_cmd.scan_rd = 1'b1;
                    n_state = S_SCHK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCHK: if (w_free) begin
                w_push = 1'b1;
                w_kind = fadu_pkg::KIND_OPEN;
                w_addr = i_scan_addr;
                w_port = i_scan_port;
                w_last = !i_sts.scan_more;
                n_state = S_SRD;
            end
            S_DRD: begin
                if (i_sts.door_match) begin
                    n_state = S_IDLE;
                end else if (i_sts.door_more) begin
                    o_cmd.door_rd = 1'b1;
                    n_state = S_DCHK;
                end else begin
                    n_state = S_DEND;
                end
            end
            S_DCHK: begin
                o_cmd.door_chk = 1'b1;
                n_state = S_DRD;
            end
            S_DEND: if (w_free) begin
                w_push = 1'b1;
                w_last = 1'b1;
                if (i_sts.door_full) begin
                    w_kind = fadu_pkg::KIND_DOOR_FULL;
                end else begin
                    o_cmd.door_store = 1'b1;
                    w_kind = fadu_pkg::KIND_CONFIRM;
                    w_addr = i_in_addr;
                    w_port = i_in_port;
                end
                n_state = S_IDLE;
            end
            S_CONF: if (w_free) begin
                w_push = 1'b1;
                w_addr = i_in_addr;
                w_port = i_in_port;
                if (!r_scan) begin
                    w_kind = fadu_pkg::KIND_OPEN;
                end else begin
                    w_kind = fadu_pkg::KIND_CONFIRM;
                    w_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_scan  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_push)
                r_ov <= 1'b1;
            else if (i_ready)
                r_ov <= 1'b0;
            if (r_state == S_CONF && w_push)
                r_scan <= !r_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid)
            r_func <= i_func;
        if (w_push) begin
            r_okind <= w_kind;
            r_oaddr <= w_addr;
            r_oport <= w_port;
            r_olast <= w_last;
        end
    end

    assign o_valid         = r_ov;
    assign o_kind          = r_okind;
    assign o_out_door_addr = r_oaddr;
    assign o_out_door_port = r_oport;
    assign o_last          = r_olast;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> (r_ov && $stable(r_okind))) else $error("word lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_free) else $error("push onto full register");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_scan) else $error("confirm phase stuck");

endmodule
`default_nettype wire

// ===== design/fire_alarm_detection_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One item at a time; ready is high only when the controller is idle, so the
// next word is taken only once the previous one has finished.
// Processing time grows with each stored detection pruned and with each
// door walked for lookup or alarm fan-out.
// Each result word sits in one output register; back-pressure stalls the walk.
// Synchronous active-low reset clears counts, alarm, state and config registers to defaults.
module fire_alarm_detection_unit #(
    parameter int DETECTION_DEPTH = 64,
    parameter int DOOR_DEPTH      = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_func,
    input  wire logic [47:0]        i_now_us,
    input  wire logic [47:0]        i_reading_time_us,
    input  wire logic signed [15:0] i_temperature,
    input  wire logic [31:0]        i_door_addr,
    input  wire logic [15:0]        i_door_port,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [2:0]              o_kind,
    output logic [31:0]             o_out_door_addr,
    output logic [15:0]             o_out_door_port,
    output logic                    o_last,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    fadu_pkg::t_cmd w_cmd;
    fadu_pkg::t_sts w_sts;
    logic [31:0] w_scan_addr, w_in_addr;
    logic [15:0] w_scan_port, w_in_port;

    assign o_cfg_ready = 1'b1;

    fadu_datapath #(
        .DETECTION_DEPTH(DETECTION_DEPTH),
        .DOOR_DEPTH     (DOOR_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_idx        (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_now_us         (i_now_us),
        .i_reading_time_us(i_reading_time_us),
        .i_temperature    (i_temperature),
        .i_door_addr      (i_door_addr),
        .i_door_port      (i_door_port),
        .o_scan_addr      (w_scan_addr),
        .o_scan_port      (w_scan_port),
        .o_in_addr        (w_in_addr),
        .o_in_port        (w_in_port)
    );

    fadu_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .o_cmd          (w_cmd),
        .i_sts          (w_sts),
        .i_scan_addr    (w_scan_addr),
        .i_scan_port    (w_scan_port),
        .i_in_addr      (w_in_addr),
        .i_in_port      (w_in_port),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_out_door_addr(o_out_door_addr),
        .o_out_door_port(o_out_door_port),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire

// ===== test/fire_alarm_detection_unit_tb.sv =====
`timescale 1ns / 1ps
module fire_alarm_detection_unit_tb;

    localparam int DET_DEPTH  = 64;
    localparam int DOOR_DEPTH = 32;
    localparam int SETTLE     = 400;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         func;
        logic [47:0]        now_us;
        logic [47:0]        stamp_us;
        logic signed [15:0] temp;
        logic [31:0]        addr;
        logic [15:0]        port;
    } t_event;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] addr;
        logic [15:0] port;
        logic        last;
    } t_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_func;
    logic [47:0]        i_now_us;
    logic [47:0]        i_reading_time_us;
    logic signed [15:0] i_temperature;
    logic [31:0]        i_door_addr;
    logic [15:0]        i_door_port;
    logic               o_valid;
    logic               i_ready;
    logic [2:0]         o_kind;
    logic [31:0]        o_out_door_addr;
    logic [15:0]        o_out_door_port;
    logic               o_last;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    fire_alarm_detection_unit i_dut (.*);

    // predictor state
    logic signed [15:0] thr_q;
    logic [6:0]         min_det_q;
    logic [30:0]        period_q;
    logic [47:0]        det_stamps [DET_DEPTH];
    int                 det_n;
    logic [47:0]        doors [DOOR_DEPTH];
    int                 door_n;
    logic               alarm_q;

    t_event  pending_events [$];
    t_result expected_results [$];
    int      errors;
    int      send_idle;
    int      recv_stall;
    bit      word_taken;
    longint  clock_us;

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic longint age_us(logic [47:0] now, logic [47:0] stamp);
        return longint'(now) - longint'(stamp);
    endfunction

    function automatic void push_result(logic [2:0] kind, logic [31:0] addr, logic [15:0] port);
        t_result r;
        r.kind = kind;
        r.addr = addr;
        r.port = port;
        r.last = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic void raise_alarm();
        alarm_q = 1'b1;
        push_result(fadu_pkg::KIND_ALARM, '0, '0);
        for (int i = 0; i < door_n; i++)
            push_result(fadu_pkg::KIND_OPEN, doors[i][47:16], doors[i][15:0]);
    endfunction

    function automatic void predict_event(t_event e);
        int n_prior;
        int kept;
        bit known;
        n_prior = expected_results.size();
        kept = 0;
        known = 0;
        if (e.func == fadu_pkg::FUNC_TEMP && !alarm_q) begin
            if (!(int'(e.temp) < int'(thr_q) ||
                  age_us(e.now_us, e.stamp_us) > longint'(period_q))) begin
                for (int i = 0; i < det_n; i++)
                    if (age_us(e.now_us, det_stamps[i]) < longint'(period_q)) begin
                        det_stamps[kept] = det_stamps[i];
                        kept++;
                    end
                det_n = kept;
                if (det_n >= DET_DEPTH) begin
                    push_result(fadu_pkg::KIND_DET_FULL, '0, '0);
                end else begin
                    det_stamps[det_n] = e.stamp_us;
                    det_n++;
                    if (det_n >= int'(min_det_q))
                        raise_alarm();
                end
            end
        end else if (e.func == fadu_pkg::FUNC_FIRE && !alarm_q) begin
            raise_alarm();
        end else if (e.func == fadu_pkg::FUNC_DOOR) begin
            if (alarm_q) begin
                push_result(fadu_pkg::KIND_OPEN, e.addr, e.port);
                push_result(fadu_pkg::KIND_CONFIRM, e.addr, e.port);
            end else begin
                for (int i = 0; i < door_n; i++)
                    if (doors[i][15:0] == e.port)
                        known = 1;
                if (!known) begin
                    if (door_n >= DOOR_DEPTH) begin
                        push_result(fadu_pkg::KIND_DOOR_FULL, '0, '0);
                    end else begin
                        doors[door_n] = {e.addr, e.port};
                        door_n++;
                        push_result(fadu_pkg::KIND_CONFIRM, e.addr, e.port);
                    end
                end
            end
        end
        if (expected_results.size() > n_prior)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

    // input, config and output sampling
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    fadu_pkg::REG_THRESHOLD: thr_q = i_cfg_data[15:0];
                    fadu_pkg::REG_MIN_DET:   min_det_q = i_cfg_data[6:0];
                    fadu_pkg::REG_PERIOD:    period_q = i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                t_event e;
                e.func = i_func;
                e.now_us = i_now_us;
                e.stamp_us = i_reading_time_us;
                e.temp = i_temperature;
                e.addr = i_door_addr;
                e.port = i_door_port;
                predict_event(e);
                word_taken = 1;
            end
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected word kind %0d", o_kind));
                end else begin
                    t_result r;
                    r = expected_results.pop_front();
                    if (o_kind !== r.kind || o_out_door_addr !== r.addr ||
                        o_out_door_port !== r.port || o_last !== r.last)
                        report_mismatch($sformatf(
                            "got k%0d %h:%h l%0b, want k%0d %h:%h l%0b",
                            o_kind, o_out_door_addr, o_out_door_port, o_last,
                            r.kind, r.addr, r.port, r.last));
                end
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || word_taken) begin
                if (pending_events.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    t_event e;
                    e = pending_events.pop_front();
                    i_func <= e.func;
                    i_now_us <= e.now_us;
                    i_reading_time_us <= e.stamp_us;
                    i_temperature <= e.temp;
                    i_door_addr <= e.addr;
                    i_door_port <= e.port;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            word_taken = 0;
            i_ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_events.size() != 0 || i_valid || expected_results.size() != 0);
        // a word may still be walking without producing a result
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_event mk(logic [1:0] func, logic [47:0] now, logic [47:0] stamp,
                                  logic signed [15:0] temp, logic [31:0] addr,
                                  logic [15:0] port);
        t_event e;
        e.func = func;
        e.now_us = now;
        e.stamp_us = stamp;
        e.temp = temp;
        e.addr = addr;
        e.port = port;
        return e;
    endfunction

    function automatic t_event rand_event(int temp_pct, int door_pct);
        t_event e;
        int pick;
        longint span;
        e.func = fadu_pkg::FUNC_TEMP;
        e.addr = $urandom;
        e.port = 16'($urandom);
        e.temp = 16'($urandom);
        pick = $urandom_range(0, 99);
        clock_us += $urandom_range(0, 50000);
        e.now_us = clock_us[47:0];
        if ($urandom_range(0, 19) == 0)
            e.now_us = 48'({$urandom, $urandom});
        span = (period_q > 31'd4000000) ? 4000000 : longint'(period_q) + 1;
        case ($urandom_range(0, 9))
            0: e.stamp_us = e.now_us + 48'($urandom_range(0, 100000));
            1: e.stamp_us = 48'({$urandom, $urandom});
            default: e.stamp_us = e.now_us - 48'($urandom_range(0, int'(span + span / 4)));
        endcase
        if ($urandom_range(0, 3) != 0)
            e.temp = 16'(int'(thr_q) + int'($urandom_range(0, 32767 - int'(thr_q))));
        if (pick < temp_pct) begin
            e.func = fadu_pkg::FUNC_TEMP;
        end else if (pick < temp_pct + door_pct) begin
            e.func = fadu_pkg::FUNC_DOOR;
            if ($urandom_range(0, 1) == 0)
                e.port = 16'($urandom_range(0, 40));
        end else begin
            e.func = ($urandom_range(0, 1) == 0) ? FUNC_UNUSED : fadu_pkg::FUNC_FIRE;
            // fire is held back until the final phase
            if (e.func == fadu_pkg::FUNC_FIRE && !alarm_q)
                e.func = FUNC_UNUSED;
        end
        return e;
    endfunction

    task automatic run_random(int count, int temp_pct, int door_pct);
        for (int m = 0; m < 4; m++) begin
            case (m)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 46; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 46; end
                default: begin send_idle = 26; recv_stall = 26; end
            endcase
            for (int k = 0; k < count / 4; k++)
                pending_events.push_back(rand_event(temp_pct, door_pct));
            do @(posedge i_clk); while (pending_events.size() != 0);
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_func = '0;
        i_now_us = '0;
        i_reading_time_us = '0;
        i_temperature = '0;
        i_door_addr = '0;
        i_door_port = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        errors = 0;
        send_idle = 0;
        recv_stall = 0;
        word_taken = 0;
        clock_us = 64'd5000000;
        thr_q = 16'sd0;
        min_det_q = 7'd1;
        period_q = 31'd1000000;
        det_n = 0;
        door_n = 0;
        alarm_q = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: well above the depth so no alarm while filling
        cfg_write(fadu_pkg::REG_MIN_DET, 32'd100);
        cfg_write(fadu_pkg::REG_THRESHOLD, 32'd100);
        cfg_write(fadu_pkg::REG_PERIOD, 32'd1000);
        pending_events.push_back(mk(FUNC_UNUSED, 48'd10000, 48'd10000, 16'sd500, '1, '1));
        pending_events.push_back(mk(fadu_pkg::FUNC_TEMP, 48'd10000, 48'd10000, 16'sd99,
                                    '0, '0));
        pending_events.push_back(mk(fadu_pkg::FUNC_TEMP, 48'd10000, 48'd10000, -16'sd32768,
                                    '0, '0));
        pending_events.push_back(mk(fadu_pkg::FUNC_TEMP, 48'd10000, 48'd10000, 16'sd100,
                                    '0, '0));
        pending_events.push_back(mk(fadu_pkg::FUNC_TEMP, 48'd10000, 48'd8999, 16'sd32767,
                                    '0, '0));
        pending_events.push_back(mk(fadu_pkg::FUNC_TEMP, 48'd10000, 48'd9000, 16'sd32767,
                                    '0, '0));
        pending_events.push_back(mk(fadu_pkg::FUNC_TEMP, 48'd10500, 48'd20000, 16'sd200,
                                    '0, '0));
        pending_events.push_back(mk(fadu_pkg::FUNC_TEMP, 48'hFFFF_FFFF_FFFF,
                                    48'hFFFF_FFFF_FFFF, 16'sd300, '0, '0));
        pending_events.push_back(mk(fadu_pkg::FUNC_TEMP, 48'd0, 48'd0, 16'sd300, '0, '0));
        pending_events.push_back(mk(fadu_pkg::FUNC_DOOR, 48'd0, 48'd0, 16'sd0,
                                    32'h0, 16'h0));
        pending_events.push_back(mk(fadu_pkg::FUNC_DOOR, 48'd1, 48'd0, 16'sd0,
                                    32'hFFFF_FFFF, 16'hFFFF));
        pending_events.push_back(mk(fadu_pkg::FUNC_DOOR, 48'd2, 48'd0, 16'sd0,
                                    32'h1234_5678, 16'hFFFF));
        pending_events.push_back(mk(fadu_pkg::FUNC_DOOR, 48'd3, 48'd0, 16'sd0,
                                    32'hC0A8_0001, 16'h5555));
        pending_events.push_back(mk(fadu_pkg::FUNC_DOOR, 48'd4, 48'd0, 16'sd0,
                                    32'h0A00_0001, 16'hAAAA));
        wait_idle();

        // long window: store fills and flags full
        cfg_write(fadu_pkg::REG_PERIOD, 32'h7FFF_FFFF);
        cfg_write(fadu_pkg::REG_THRESHOLD, 32'hFFFF_8000);
        run_random(80, 85, 15);

        // zero window prunes all but future stamps
        cfg_write(fadu_pkg::REG_PERIOD, 32'd0);
        cfg_write(fadu_pkg::REG_THRESHOLD, 32'h0000_7FFF);
        run_random(40, 60, 30);

        // door table fills, mid-range window
        cfg_write(fadu_pkg::REG_PERIOD, 32'd200000);
        cfg_write(fadu_pkg::REG_THRESHOLD, 32'd0);
        cfg_write(fadu_pkg::REG_MIN_DET, 32'd127);
        run_random(60, 40, 55);

        // raise the alarm, by count or by fire as the seed decides
        if ($urandom_range(0, 1) == 0) begin
            cfg_write(fadu_pkg::REG_MIN_DET, 32'd1);
            cfg_write(fadu_pkg::REG_PERIOD, 32'd1000000);
        end else begin
            pending_events.push_back(mk(fadu_pkg::FUNC_FIRE, 48'd0, 48'd0, 16'sd0, '0, '0));
        end
        pending_events.push_back(mk(fadu_pkg::FUNC_TEMP, clock_us[47:0], clock_us[47:0],
                                    16'sd32767, '0, '0));
        wait_idle();
        pending_events.push_back(mk(fadu_pkg::FUNC_FIRE, 48'd0, 48'd0, 16'sd0, '0, '0));
        run_random(40, 30, 50);

        if (errors == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/fadu_pkg.sv
design/fadu_datapath.sv
design/fadu_ctrl.sv
design/fire_alarm_detection_unit.sv
test/fire_alarm_detection_unit_tb.sv
